/* hw/rtl/mfik_pkg.sv */
// shared types, constants and tables for the mecanum field inverse kinematics core
package mfik_pkg;

    // rotation stages requested, clamped to the arctangent table length
    localparam int ROTATION_STAGES = 16;
    localparam int ATAN_LEN = 24;
    localparam int CORDIC_STAGES = (ROTATION_STAGES > ATAN_LEN) ? ATAN_LEN :
                                   (ROTATION_STAGES < 1) ? 1 : ROTATION_STAGES;

    // datapath widths
    localparam int FW = 16;             // input field width
    localparam int GW = 24;             // gain width
    localparam int RW = 24;             // result field width
    localparam int CW = 32;             // cordic x, y, z width
    localparam int PW = FW + CW;        // velocity times sine or cosine
    localparam int VW = 34;             // rotated velocity in Q16
    localparam int XW = VW + GW + 1;    // scaled linear term
    localparam int TW = FW + GW + 1 + 12; // scaled rotation term
    localparam int SW = 61;             // wheel sum
    localparam int ROUND_SHIFT = 36;

    // back end pipeline: cordic stages plus six arithmetic stages
    localparam int BACK_LATENCY = CORDIC_STAGES + 6;
    localparam int OUT_AW = $clog2(BACK_LATENCY + 2);
    localparam int OUT_DEPTH = 1 << OUT_AW;
    localparam int CREDIT_W = $clog2(OUT_DEPTH + 1);

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

    // configuration port
    localparam int CFG_IW = 4;
    localparam logic [CFG_IW-1:0] REG_LINEAR_GAIN = CFG_IW'(0);
    localparam logic [CFG_IW-1:0] REG_ROTATION_GAIN = CFG_IW'(1);
    localparam logic [GW-1:0] GAIN_RESET = GW'(65536);

    // arithmetic constants
    localparam logic signed [CW-1:0] CORDIC_K = CW'(652032874);
    localparam logic signed [SW-1:0] ROUND_HALF = SW'(64'h0000_0008_0000_0000);
    localparam logic signed [RW:0] OUT_MAX = (RW+1)'(8388607);
    localparam logic signed [RW:0] OUT_MIN = -(RW+1)'(8388608);

    // arctangent of 2^-i in units of 1/6553600 degree
    localparam logic signed [CW-1:0] ATAN_TABLE [ATAN_LEN] = '{
        CW'(294912000), CW'(174096719), CW'(91987925), CW'(46694507),
        CW'(23437865),  CW'(11730358),  CW'(5866610),  CW'(2933484),
        CW'(1466764),   CW'(733385),    CW'(366693),   CW'(183346),
        CW'(91673),     CW'(45837),     CW'(22918),    CW'(11459),
        CW'(5730),      CW'(2865),      CW'(1432),     CW'(716),
        CW'(358),       CW'(179),       CW'(90),       CW'(45)
    };

    typedef struct packed {
        logic signed [FW-1:0] vel_x;
        logic signed [FW-1:0] vel_y;
        logic signed [FW-1:0] yaw_rate;
        logic signed [FW-1:0] heading;
    } command_t;

    typedef struct packed {
        logic signed [RW-1:0] wheel_one_rpm;
        logic signed [RW-1:0] wheel_two_rpm;
        logic signed [RW-1:0] wheel_three_rpm;
        logic signed [RW-1:0] wheel_four_rpm;
    } result_t;

    // velocities and rate that ride along the rotation
    typedef struct packed {
        logic signed [FW-1:0] lx;
        logic signed [FW-1:0] ly;
        logic signed [FW-1:0] wz;
        logic                 neg;
    } side_t;

    // classified word from front to back
    typedef struct packed {
        side_t                side;
        logic signed [CW-1:0] angle;
    } job_t;

    typedef struct packed {
        logic [GW-1:0] linear_gain;
        logic [GW-1:0] rotation_gain;
    } gains_t;

endpackage

/* hw/rtl/mfik_front.sv */
// front end: takes command words, folds the heading into the cordic range
module mfik_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  mfik_pkg::command_t command,
    output logic              q_push,
    input  logic              q_full,
    output mfik_pkg::job_t    job
);
    import mfik_pkg::*;

    localparam logic signed [FW:0] HALF_TURN = (FW+1)'(18000);
    localparam logic signed [FW:0] FULL_TURN = (FW+1)'(36000);
    localparam logic signed [FW:0] RIGHT_ANGLE = (FW+1)'(9000);

    logic         valid_reg, valid_next;
    job_t         job_reg;
    job_t         job_next;
    logic         advance;
    logic         accept;
    logic signed [FW:0] h_ext, h_wrap, h_fold;
    logic         neg;

    // hold stage moves when empty or when the queue takes the word
    assign advance = !valid_reg || !q_full;
    assign full    = !advance;
    assign accept  = push && advance;
    assign q_push  = valid_reg && !q_full;
    assign job     = job_reg;

    // wrap heading into one turn, then fold into the right half plane
    always_comb
    begin
        h_ext = (FW+1)'(command.heading);
        if (h_ext >= HALF_TURN)
            h_wrap = h_ext - FULL_TURN;
        else if (h_ext < -HALF_TURN)
            h_wrap = h_ext + FULL_TURN;
        else
            h_wrap = h_ext;

        neg = 1'b0;
        if (h_wrap > RIGHT_ANGLE)
        begin
            h_fold = h_wrap - HALF_TURN;
            neg    = 1'b1;
        end
        else if (h_wrap < -RIGHT_ANGLE)
        begin
            h_fold = h_wrap + HALF_TURN;
            neg    = 1'b1;
        end
        else
        begin
            h_fold = h_wrap;
        end

        job_next.side.lx  = command.vel_x;
        job_next.side.ly  = command.vel_y;
        job_next.side.wz  = command.yaw_rate;
        job_next.side.neg = neg;
        job_next.angle    = {h_fold[FW-1:0], 16'h0000};
    end

    // valid flag of the hold stage
    always_comb
    begin
        if (advance)
            valid_next = push;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // payload of the hold stage
    always_ff @(posedge clk)
    begin
        if (accept)
            job_reg <= job_next;
    end

endmodule

/* hw/rtl/mfik_queue.sv */
// short queue of classified words between front and back
module mfik_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           full,
    input  mfik_pkg::job_t wr_data,
    input  logic           pop,
    output logic           empty,
    output mfik_pkg::job_t rd_data
);
    import mfik_pkg::*;

    job_t                mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg, count_next;
    logic                do_push, do_pop;

    assign full    = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (QUEUE_AW+1)'(do_push) - (QUEUE_AW+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

/* hw/rtl/mfik_back.sv */
// back end: cordic rotation, gain multiply, wheel mixing and result queue
module mfik_back (
    input  logic             clk,
    input  logic             rst_n,
    input  mfik_pkg::gains_t gains,
    input  logic             q_empty,
    output logic             q_pop,
    input  mfik_pkg::job_t   job,
    output logic             empty,
    input  logic             pop,
    output mfik_pkg::result_t result
);
    import mfik_pkg::*;

    // shift down the sum (rounding half is already added), then clamp to the result range
    function automatic logic signed [RW-1:0] saturate(input logic signed [SW-1:0] v);
        logic signed [SW-1:0]             r;
        logic signed [SW-ROUND_SHIFT-1:0] q;
        r = v >>> ROUND_SHIFT;
        q = r[SW-ROUND_SHIFT-1:0];
        if (q > (SW-ROUND_SHIFT)'(OUT_MAX))
            return OUT_MAX[RW-1:0];
        else if (q < (SW-ROUND_SHIFT)'(OUT_MIN))
            return OUT_MIN[RW-1:0];
        else
            return q[RW-1:0];
    endfunction

    // valid bits of the whole back pipeline
    logic [BACK_LATENCY-1:0] vld_reg;
    logic [CREDIT_W-1:0]     credit_reg, credit_next;
    logic                    issue;
    logic                    out_write, out_read;

    // cordic stages
    logic signed [CW-1:0] cx_reg [CORDIC_STAGES];
    logic signed [CW-1:0] cy_reg [CORDIC_STAGES];
    logic signed [CW-1:0] cz_reg [CORDIC_STAGES];
    side_t                side_reg [CORDIC_STAGES];
    logic signed [CW-1:0] cx_in [CORDIC_STAGES];
    logic signed [CW-1:0] cy_in [CORDIC_STAGES];
    logic signed [CW-1:0] cz_in [CORDIC_STAGES];
    side_t                side_in [CORDIC_STAGES];

    // arithmetic stages
    logic signed [CW-1:0]   cos_reg, sin_reg;
    logic signed [FW-1:0]   s1_lx_reg, s1_ly_reg, s1_wz_reg;
    logic signed [PW-1:0]   pxc_reg, pys_reg, pyc_reg, pxs_reg;
    logic signed [FW+GW:0]  prot_reg;
    logic signed [PW:0]     vx_sum, vy_sum;
    logic signed [VW-1:0]   vx_reg, vy_reg;
    logic signed [TW-1:0]   tr_reg, tr4_reg;
    logic signed [XW-1:0]   xs_reg, ys_reg;
    logic signed [SW-1:0]   plus_reg, minus_reg, tp_reg, tn_reg;
    logic signed [SW-1:0]   w_reg [4];
    result_t                res_next;

    // result queue
    result_t             out_mem [OUT_DEPTH];
    logic [OUT_AW-1:0]   out_wr_reg, out_rd_reg;
    logic [OUT_AW:0]     out_count_reg, out_count_next;

    // issue a word only when a result slot is reserved for it
    assign issue = !q_empty && (credit_reg < CREDIT_W'(OUT_DEPTH));
    assign q_pop = issue;

    assign out_write = vld_reg[BACK_LATENCY-1];
    assign out_read  = pop && !empty;

    always_comb
    begin
        credit_next = credit_reg + CREDIT_W'(issue) - CREDIT_W'(out_read);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            credit_reg <= '0;
        end
        else
        begin
            vld_reg    <= {vld_reg[BACK_LATENCY-2:0], issue};
            credit_reg <= credit_next;
        end
    end

    // stage inputs: first stage from the queue, others from the stage before
    always_comb
    begin
        for (int i = 0; i < CORDIC_STAGES; i++)
        begin
            if (i == 0)
            begin
                cx_in[i]   = CORDIC_K;
                cy_in[i]   = '0;
                cz_in[i]   = job.angle;
                side_in[i] = job.side;
            end
            else
            begin
                cx_in[i]   = cx_reg[i-1];
                cy_in[i]   = cy_reg[i-1];
                cz_in[i]   = cz_reg[i-1];
                side_in[i] = side_reg[i-1];
            end
        end
    end

    // one micro-rotation per stage
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < CORDIC_STAGES; i++)
        begin
            side_reg[i] <= side_in[i];
            if (!cz_in[i][CW-1])
            begin
                cx_reg[i] <= cx_in[i] - (cy_in[i] >>> i);
                cy_reg[i] <= cy_in[i] + (cx_in[i] >>> i);
                cz_reg[i] <= cz_in[i] - ATAN_TABLE[i];
            end
            else
            begin
                cx_reg[i] <= cx_in[i] + (cy_in[i] >>> i);
                cy_reg[i] <= cy_in[i] - (cx_in[i] >>> i);
                cz_reg[i] <= cz_in[i] + ATAN_TABLE[i];
            end
        end
    end

    // velocity sums in Q30, floored to Q16
    always_comb
    begin
        vx_sum = (PW+1)'(pxc_reg) + (PW+1)'(pys_reg);
        vy_sum = (PW+1)'(pyc_reg) - (PW+1)'(pxs_reg);
    end

    // result word from the rounded wheel sums
    always_comb
    begin
        res_next.wheel_one_rpm   = saturate(w_reg[0]);
        res_next.wheel_two_rpm   = saturate(w_reg[1]);
        res_next.wheel_three_rpm = saturate(w_reg[2]);
        res_next.wheel_four_rpm  = saturate(w_reg[3]);
    end

    // arithmetic pipeline after the rotation
    always_ff @(posedge clk)
    begin
        // undo the quadrant fold
        cos_reg   <= side_reg[CORDIC_STAGES-1].neg ? -cx_reg[CORDIC_STAGES-1]
                                                   : cx_reg[CORDIC_STAGES-1];
        sin_reg   <= side_reg[CORDIC_STAGES-1].neg ? -cy_reg[CORDIC_STAGES-1]
                                                   : cy_reg[CORDIC_STAGES-1];
        s1_lx_reg <= side_reg[CORDIC_STAGES-1].lx;
        s1_ly_reg <= side_reg[CORDIC_STAGES-1].ly;
        s1_wz_reg <= side_reg[CORDIC_STAGES-1].wz;

        // products with sine and cosine, rate times rotation gain
        pxc_reg  <= s1_lx_reg * cos_reg;
        pys_reg  <= s1_ly_reg * sin_reg;
        pyc_reg  <= s1_ly_reg * cos_reg;
        pxs_reg  <= s1_lx_reg * sin_reg;
        prot_reg <= s1_wz_reg * $signed({1'b0, gains.rotation_gain});

        // body frame velocities
        vx_reg <= vx_sum[VW+13:14];
        vy_reg <= vy_sum[VW+13:14];
        tr_reg <= {prot_reg, 12'h000};

        // linear gain
        xs_reg  <= vx_reg * $signed({1'b0, gains.linear_gain});
        ys_reg  <= vy_reg * $signed({1'b0, gains.linear_gain});
        tr4_reg <= tr_reg;

        // partial sums with rounding folded into the rotation term
        plus_reg  <= SW'(xs_reg) + SW'(ys_reg);
        minus_reg <= SW'(xs_reg) - SW'(ys_reg);
        tp_reg    <= SW'(tr4_reg) + ROUND_HALF;
        tn_reg    <= ROUND_HALF - SW'(tr4_reg);

        // wheel mix
        w_reg[0] <= minus_reg + tn_reg;
        w_reg[1] <= plus_reg + tp_reg;
        w_reg[2] <= plus_reg + tn_reg;
        w_reg[3] <= minus_reg + tp_reg;
    end

    // result queue control
    assign empty  = (out_count_reg == '0);
    assign result = out_mem[out_rd_reg];

    always_comb
    begin
        out_count_next = out_count_reg + (OUT_AW+1)'(out_write) - (OUT_AW+1)'(out_read);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_wr_reg    <= '0;
            out_rd_reg    <= '0;
            out_count_reg <= '0;
        end
        else
        begin
            if (out_write)
                out_wr_reg <= out_wr_reg + 1'b1;
            if (out_read)
                out_rd_reg <= out_rd_reg + 1'b1;
            out_count_reg <= out_count_next;
        end
    end

    // result storage
    always_ff @(posedge clk)
    begin
        if (out_write)
            out_mem[out_wr_reg] <= res_next;
    end

    // credits account for every word in flight or waiting
    a_credit_balance: assert property (@(posedge clk) disable iff (!rst_n)
        credit_reg == CREDIT_W'($countones(vld_reg)) + CREDIT_W'(out_count_reg))
        else $error("credit count out of step with words in flight");

    // a finished word always finds room in the result queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        out_write |-> (out_count_reg < (OUT_AW+1)'(OUT_DEPTH)) || out_read)
        else $error("result queue overflow");

    // an issued word reaches the result queue after the pipeline latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        issue |-> ##BACK_LATENCY out_write)
        else $error("issued word did not reach the result queue");

endmodule

/* hw/rtl/mecanum_field_inverse_kinematics_core.sv */
// top level of the mecanum field inverse kinematics core
//
// Command words enter through push/full: a word is taken on a rising edge with
// push high and full low. Each word carries x and y velocity, yaw rate and the
// gyro heading. Every word yields exactly one result word of four wheel speed
// targets, in arrival order, read through empty/pop: the oldest result sits on
// the result port while empty is low and leaves on an edge with pop high.
// The cfg channel writes the linear and rotation gains (index 0 and 1, other
// indexes are ignored); cfg_ready is always high. Write gains only while idle.
// From accept to empty falling, a word passes one hold stage, the classification
// queue, one cordic stage per rotation step and six multiply and mix stages, and
// is then written into the result queue. Throughput is one word per cycle, set by
// the fully pipelined rotation, while the back end holds a free result credit.
// When the reader stalls, results collect in the result queue; the back end
// stops issuing once queue plus pipeline hold a full queue's worth, then the
// front queue fills and full rises. Nothing is dropped.
// Reset empties both queues and the pipeline and sets both gains to 1.0.
module mecanum_field_inverse_kinematics_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  mfik_pkg::command_t            command,
    output logic                          empty,
    input  logic                          pop,
    output mfik_pkg::result_t             result,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mfik_pkg::CFG_IW-1:0]   cfg_index,
    input  logic [mfik_pkg::GW-1:0]       cfg_data
);
    import mfik_pkg::*;

    gains_t gains_reg, gains_next;
    logic   fq_push, fq_full;
    job_t   front_job;
    logic   bq_pop, bq_empty;
    job_t   back_job;

    assign cfg_ready = 1'b1;

    // gain register writes
    always_comb
    begin
        gains_next = gains_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_LINEAR_GAIN:   gains_next.linear_gain = cfg_data;
                REG_ROTATION_GAIN: gains_next.rotation_gain = cfg_data;
                default:           gains_next = gains_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gains_reg.linear_gain   <= GAIN_RESET;
            gains_reg.rotation_gain <= GAIN_RESET;
        end
        else
        begin
            gains_reg <= gains_next;
        end
    end

    // front end
    mfik_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .command (command),
        .q_push  (fq_push),
        .q_full  (fq_full),
        .job     (front_job)
    );

    // queue between front and back
    mfik_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (fq_push),
        .full    (fq_full),
        .wr_data (front_job),
        .pop     (bq_pop),
        .empty   (bq_empty),
        .rd_data (back_job)
    );

    // back end
    mfik_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .gains   (gains_reg),
        .q_empty (bq_empty),
        .q_pop   (bq_pop),
        .job     (back_job),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule
